### src/itrd_pkg.sv
`timescale 1ns / 1ps

package itrd_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 31;

  // long-division bits retired per cycle by the shared divide unit
  localparam int STEP_BITS = 8;
  localparam int BYTE_BITS = 8;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int OUT_W   = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'd65;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    logic [CHAR_W-1:0] res;
    dw = {1'b0, d};
    if (d < DEC_DIGITS) begin
      res = ASCII_ZERO + dw;
    end else begin
      res = ASCII_A + dw - {1'b0, DEC_DIGITS};
    end
    return res;
  endfunction

endpackage

### src/itrd_div_step.sv
`timescale 1ns / 1ps

// Shared divide unit: long division of one chunk by the radix, with the
// running remainder from the more significant chunks.
module itrd_div_step (
  input  logic [itrd_pkg::RADIX_W-1:0]   radix,
  input  logic [itrd_pkg::RADIX_W-1:0]   rem_in,
  input  logic [itrd_pkg::STEP_BITS-1:0] dvd,
  output logic [itrd_pkg::STEP_BITS-1:0] quo,
  output logic [itrd_pkg::RADIX_W-1:0]   rem_out
);
  import itrd_pkg::*;

  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [RADIX_W:0]   trial;
    r   = rem_in;
    quo = '0;
    // r stays below radix, so the shifted trial fits in RADIX_W+1 bits
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {r, dvd[i]};
      if (trial >= {1'b0, radix}) begin
        r      = RADIX_W'(trial - {1'b0, radix});
        quo[i] = 1'b1;
      end else begin
        r = RADIX_W'(trial);
      end
    end
    rem_out = r;
  end

endmodule

### src/itrd_digit_store.sv
`timescale 1ns / 1ps

// Digit buffer, least significant digit at address 0; registered read.
module itrd_digit_store #(
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
  localparam int AW = $clog2(MAX_DIGITS)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [itrd_pkg::RADIX_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic [itrd_pkg::RADIX_W-1:0] rd_data
);
  import itrd_pkg::*;

  logic [RADIX_W-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### src/integer_to_radix_digits.sv
`timescale 1ns / 1ps

// Converts each accepted value to ASCII digits in the configured radix
// (2..36; register values 0..1 act as 2, 37..63 as 36), most significant
// digit first, no leading zeros, zero as a single '0', tlast on the final
// character. The radix register may only be written while the block is idle.
// One value is converted at a time and s_tready is low until its last
// character sits in the output register. Each digit comes from a divide unit
// that retires 8 dividend bits per cycle, starting at the top 8-bit chunk
// for the first digit and, for each further digit, at the highest nonzero
// chunk of the running quotient; every character is then read from the
// digit buffer and loaded into the output register.
module integer_to_radix_digits #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF,
  localparam int DATA_W =
    ((VALUE_BITS + itrd_pkg::BYTE_BITS - 1) / itrd_pkg::BYTE_BITS) * itrd_pkg::BYTE_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         radix_we,
  input  logic [itrd_pkg::RADIX_W-1:0] radix_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [DATA_W-1:0]            s_tdata,   // [VALUE_BITS-1:0] value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [itrd_pkg::OUT_W-1:0]   m_tdata,   // [6:0] digit_char
  output logic                         m_tlast
);
  import itrd_pkg::*;

  localparam int NCHUNK = DATA_W / STEP_BITS;
  localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CW     = $clog2(MAX_DIGITS + 1);
  localparam int AW     = $clog2(MAX_DIGITS);
  localparam logic [CIW-1:0] TOP_CHUNK   = CIW'(NCHUNK - 1);
  localparam logic [CW-1:0]  DIGIT_LIMIT = CW'(MAX_DIGITS);

  state_t               state;
  logic [RADIX_W-1:0]   radix_cfg;
  logic [RADIX_W-1:0]   base;
  logic [DATA_W-1:0]    quo;
  logic [RADIX_W-1:0]   rem;
  logic [CIW-1:0]       cidx;
  logic [CIW-1:0]       top_idx;
  logic                 nz;
  logic [CW-1:0]        cnt;
  logic [AW-1:0]        rd_addr;

  logic [STEP_BITS-1:0] chunk_in;
  logic [STEP_BITS-1:0] chunk_q;
  logic [RADIX_W-1:0]   rem_out;
  logic [RADIX_W-1:0]   rd_data;
  logic                 qc_nz;
  logic                 digit_end;
  logic                 stop;
  logic [CW-1:0]        cnt_next;
  logic                 wr_en;
  logic                 out_free;
  logic                 out_load;

  assign chunk_in  = quo[int'(cidx) * STEP_BITS +: STEP_BITS];
  assign qc_nz     = |chunk_q;
  assign digit_end = (cidx == '0);
  assign cnt_next  = cnt + 1'b1;
  assign stop      = !(nz || qc_nz) || (cnt_next == DIGIT_LIMIT);
  assign wr_en     = (state == ST_DIV) && digit_end;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = (state == ST_OUT) && out_free;
  assign s_tready  = (state == ST_IDLE);

  itrd_div_step u_div (
    .radix   (base),
    .rem_in  (rem),
    .dvd     (chunk_in),
    .quo     (chunk_q),
    .rem_out (rem_out)
  );

  itrd_digit_store #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[AW-1:0]),
    .wr_data (rem_out),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      radix_cfg <= RADIX_RESET;
      m_tvalid  <= 1'b0;
    end else begin
      if (radix_we) begin
        radix_cfg <= radix_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            quo   <= DATA_W'(s_tdata[VALUE_BITS-1:0]);
            base  <= sat_radix(radix_cfg);
            cidx  <= TOP_CHUNK;
            rem   <= '0;
            nz    <= 1'b0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo[int'(cidx) * STEP_BITS +: STEP_BITS] <= chunk_q;
          if (digit_end) begin
            cnt <= cnt_next;
            rem <= '0;
            nz  <= 1'b0;
            if (stop) begin
              rd_addr <= cnt[AW-1:0];
              state   <= ST_RD;
            end else begin
              cidx <= nz ? top_idx : '0;
            end
          end else begin
            rem  <= rem_out;
            cidx <= cidx - 1'b1;
            // remember the highest nonzero quotient chunk for the next digit
            if (!nz && qc_nz) begin
              nz      <= 1'b1;
              top_idx <= cidx;
            end
          end
        end
        ST_RD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tdata <= {{(OUT_W - CHAR_W){1'b0}}, digit_ascii(rd_data)};
            m_tlast <= (rd_addr == '0);
            if (rd_addr == '0) begin
              state <= ST_IDLE;
            end else begin
              rd_addr <= rd_addr - 1'b1;
              state   <= ST_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/itrd_checker.sv
`timescale 1ns / 1ps

module itrd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [itrd_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast
);
  import itrd_pkg::*;

  // a conversion occupies the block for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted back to back");

  // while a non-final character waits, the conversion is not finished
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> !s_tready)
    else $error("ready before final character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7] == 1'b0) &&
      ((m_tdata[6:0] >= 7'd48 && m_tdata[6:0] <= 7'd57) ||
       (m_tdata[6:0] >= 7'd65 && m_tdata[6:0] <= 7'd90)))
    else $error("output is not a digit character");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (.*);
